>>> sv/npf_pkg.sv
// ----------------------------------------------------------------------------
// npf_pkg: shared types and constants of the nested section profiler
// Request and status codes, sequencer states, field widths, the interval cap
// and the packed per-metric statistics record.
// ----------------------------------------------------------------------------
package npf_pkg;

	// field widths of the request and response channels
	localparam int REQ_W      = 2;
	localparam int METRIC_W   = 5;
	localparam int TIME_W     = 48;
	localparam int STATUS_W   = 3;
	localparam int SUM_W      = 64;
	localparam int RUN_W      = 30;
	localparam int CNT_W      = 32;
	localparam int DEPTH_OUT_W = 4;

	// default sizing
	localparam int STACK_DEPTH_DEF  = 8;
	localparam int METRIC_COUNT_DEF = 32;

	// every interval and every run saturates at 600 s
	localparam logic [RUN_W-1:0] CAP_US = 30'd600_000_000;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH = 2'd0,
		REQ_POP  = 2'd1,
		REQ_READ = 2'd2,
		REQ_NOP  = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_RANGE = 3'd3,
		ST_DUP   = 3'd4
	} status_t;

	// what the sequencer does with an accepted request
	typedef enum logic [1:0] {
		OP_RESP = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_LOAD = 2'd1,
		S_FOLD = 2'd2,
		S_UPD  = 2'd3
	} state_t;

	// shift control for the row of stack cells
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	// completed-run statistics of one metric
	typedef struct packed {
		logic [SUM_W-1:0] total;
		logic [RUN_W-1:0] longest;
		logic [CNT_W-1:0] runs;
	} stats_t;

endpackage

>>> sv/npf_req_if.sv
// ----------------------------------------------------------------------------
// npf_req_if: request channel of the section profiler
// Valid/ready channel carrying request type, metric index and timestamp.
// ----------------------------------------------------------------------------
interface npf_req_if import npf_pkg::*;;
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [METRIC_W-1:0] metric;
	logic [TIME_W-1:0]   now_us;

	modport source (output valid, output req_type, output metric, output now_us, input ready);
	modport sink (input valid, input req_type, input metric, input now_us, output ready);
endinterface

>>> sv/npf_rsp_if.sv
// ----------------------------------------------------------------------------
// npf_rsp_if: response channel of the section profiler
// Valid/ready channel carrying status, statistics and stack depth.
// ----------------------------------------------------------------------------
interface npf_rsp_if import npf_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [SUM_W-1:0]       sum_us;
	logic [RUN_W-1:0]       max_us;
	logic [CNT_W-1:0]       run_count;
	logic [DEPTH_OUT_W-1:0] stack_depth;

	modport source (output valid, output status, output sum_us, output max_us,
		output run_count, output stack_depth, input ready);
	modport sink (input valid, input status, input sum_us, input max_us,
		input run_count, input stack_depth, output ready);
endinterface

>>> sv/npf_ram.sv
// ----------------------------------------------------------------------------
// npf_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle; read data holds without rd_en.
// ----------------------------------------------------------------------------
module npf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/npf_cell.sv
// ----------------------------------------------------------------------------
// npf_cell: one entry of the open-section stack
// Holds one metric index, shifts toward the bottom on push and toward the top
// on pop, and compares its entry against the pushed metric.
// ----------------------------------------------------------------------------
module npf_cell import npf_pkg::*; #(
	parameter int MW = 5
) (
	input  logic          clk,
	input  stk_ctl_t      ctl,
	input  logic [MW-1:0] from_up,
	input  logic [MW-1:0] from_dn,
	input  logic [MW-1:0] key,
	input  logic          occupied,
	output logic [MW-1:0] value,
	output logic          hit
);

	logic [MW-1:0] val_q;

	// shift with the neighbors
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			val_q <= from_up;
		end else if (ctl.pop) begin
			val_q <= from_dn;
		end
	end

	// duplicate detect on an occupied entry
	assign hit   = occupied && (val_q == key);
	assign value = val_q;

endmodule

>>> sv/nested_section_latency_profiler_top.sv
// ----------------------------------------------------------------------------
// nested_section_latency_profiler_top: exclusive-time profiler for nested sections
// Stack of open metrics as a row of shift cells, per-metric timing and
// statistics in memories, and a short sequencer for the read-modify-write.
// ----------------------------------------------------------------------------
// Usage
//   req: valid/ready request channel (push, pop, read, no-op) with a metric
//   index and a microsecond timestamp. rsp: valid/ready response channel with
//   one result per request: status, sum, max, run count and stack depth.
//   One request is processed at a time; req.ready is high while the
//   sequencer is idle. Steps from acceptance to the response register:
//     read, error and no-op: memory read
//     push: memory read, then fold of the paused metric
//     pop:  memory read, fold, then the 64-bit sum update
//   The steps follow from the registered memory read and the chain of the
//   48-bit elapsed-time subtract, the run accumulate and the sum update.
//   The response sits in an output register; while the receiver stalls, the
//   sequencer holds its final step and the next request waits.
//   Reset (arst_n low) empties the stack and marks all statistics as zero
//   through one valid bit per metric; no clearing pass is needed.
// ----------------------------------------------------------------------------
module nested_section_latency_profiler_top import npf_pkg::*; #(
	parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int METRIC_COUNT = METRIC_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	npf_req_if.sink   req,
	npf_rsp_if.source rsp
);

	localparam int MW = $clog2(METRIC_COUNT);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int SW = $bits(stats_t);

	state_t              state_q, state_d;
	logic [DW-1:0]       depth_q;
	logic [MW-1:0]       cell_q [STACK_DEPTH];
	logic [MW-1:0]       up_w [STACK_DEPTH];
	logic [MW-1:0]       dn_w [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] hit;
	stk_ctl_t            stk_ctl;

	logic                accept;
	req_type_t           rtype;
	logic [MW-1:0]       m_in;
	logic                range_err, full, empty, dup;
	op_t                 op_d, op_q;
	status_t             status_d, status_q;
	logic [MW-1:0]       tgt_d;

	logic [TIME_W-1:0]   now_q;
	logic [MW-1:0]       top_q, below_q, tgt_q;
	logic                has_prev_q, has_below_q;
	logic [METRIC_COUNT-1:0] vld_q;

	logic [TIME_W-1:0]   stamp_rd;
	logic [RUN_W-1:0]    run_rd;
	logic [SW-1:0]       stats_rd;
	logic                stamp_we, run_we, stats_we;
	logic [MW-1:0]       stamp_wa, run_wa;
	logic [TIME_W-1:0]   stamp_wd;
	logic [RUN_W-1:0]    run_wd;

	logic [TIME_W-1:0]   diff;
	logic [RUN_W-1:0]    d_sat, d_q, run_q, acc, acc_q;
	logic [RUN_W:0]      acc_sum;
	stats_t              stats_cur, stats_q, stats_upd, res_stats;
	logic [SUM_W:0]      sum_full;

	logic                out_free, produce;
	logic                out_vld_q;
	status_t             res_status, out_status_q;
	stats_t              out_stats_q;
	logic [DEPTH_OUT_W-1:0] out_depth_q;

	// request decode and checks
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rtype     = req_type_t'(req.req_type);
	assign m_in      = MW'(req.metric);
	assign range_err = int'(req.metric) >= METRIC_COUNT;
	assign full      = depth_q >= DW'(STACK_DEPTH);
	assign empty     = (depth_q == '0);
	assign dup       = |hit;

	always_comb begin
		op_d     = OP_RESP;
		status_d = ST_OK;
		case (rtype)
			REQ_PUSH: begin
				if (range_err) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else if (dup) begin
					status_d = ST_DUP;
				end else begin
					op_d = OP_PUSH;
				end
			end
			REQ_POP: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					op_d = OP_POP;
				end
			end
			REQ_READ: begin
				if (range_err) begin
					status_d = ST_RANGE;
				end else begin
					op_d = OP_READ;
				end
			end
			default: begin
			end
		endcase
	end

	assign stk_ctl.push = accept && (op_d == OP_PUSH);
	assign stk_ctl.pop  = accept && (op_d == OP_POP);
	assign tgt_d        = (op_d == OP_POP) ? cell_q[0] : m_in;

	// row of stack cells, top of stack in cell 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign up_w[i] = m_in;
		end else begin : g_next
			assign up_w[i] = cell_q[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign dn_w[i] = cell_q[i];
		end else begin : g_inner
			assign dn_w[i] = cell_q[i+1];
		end
		npf_cell #(
			.MW(MW)
		) u_cell (
			.clk      (clk),
			.ctl      (stk_ctl),
			.from_up  (up_w[i]),
			.from_dn  (dn_w[i]),
			.key      (m_in),
			.occupied (DW'(i) < depth_q),
			.value    (cell_q[i]),
			.hit      (hit[i])
		);
	end

	// stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (stk_ctl.push) begin
			depth_q <= depth_q + DW'(1);
		end else if (stk_ctl.pop) begin
			depth_q <= depth_q - DW'(1);
		end
	end

	// request context captured at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_RESP;
		end else if (accept) begin
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			now_q       <= req.now_us;
			top_q       <= cell_q[0];
			below_q     <= cell_q[1];
			tgt_q       <= tgt_d;
			has_prev_q  <= !empty;
			has_below_q <= depth_q > DW'(1);
		end
	end

	// per-metric memories: start stamp, current run, completed statistics
	npf_ram #(
		.WIDTH (TIME_W),
		.DEPTH (METRIC_COUNT)
	) u_stamp_ram (
		.clk     (clk),
		.wr_en   (stamp_we),
		.wr_addr (stamp_wa),
		.wr_data (stamp_wd),
		.rd_en   (accept),
		.rd_addr (cell_q[0]),
		.rd_data (stamp_rd)
	);

	npf_ram #(
		.WIDTH (RUN_W),
		.DEPTH (METRIC_COUNT)
	) u_run_ram (
		.clk     (clk),
		.wr_en   (run_we),
		.wr_addr (run_wa),
		.wr_data (run_wd),
		.rd_en   (accept),
		.rd_addr (cell_q[0]),
		.rd_data (run_rd)
	);

	npf_ram #(
		.WIDTH (SW),
		.DEPTH (METRIC_COUNT)
	) u_stats_ram (
		.clk     (clk),
		.wr_en   (stats_we),
		.wr_addr (top_q),
		.wr_data (stats_upd),
		.rd_en   (accept),
		.rd_addr (tgt_d),
		.rd_data (stats_rd)
	);

	// statistics of a metric never popped read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (stats_we) begin
			vld_q[top_q] <= 1'b1;
		end
	end

	// elapsed time since the start stamp, modulo 2^48, capped
	assign diff      = now_q - stamp_rd;
	assign d_sat     = (diff > TIME_W'(CAP_US)) ? CAP_US : diff[RUN_W-1:0];
	assign stats_cur = vld_q[tgt_q] ? stats_t'(stats_rd) : '0;

	// run accumulate, capped
	assign acc_sum = {1'b0, run_q} + {1'b0, d_q};
	assign acc     = (acc_sum > {1'b0, CAP_US}) ? CAP_US : acc_sum[RUN_W-1:0];

	// completed-run update
	assign sum_full          = {1'b0, stats_q.total} + (SUM_W+1)'(acc_q);
	assign stats_upd.total   = sum_full[SUM_W] ? '1 : sum_full[SUM_W-1:0];
	assign stats_upd.longest = (acc_q > stats_q.longest) ? acc_q : stats_q.longest;
	assign stats_upd.runs    = (&stats_q.runs) ? stats_q.runs : stats_q.runs + CNT_W'(1);

	// pipeline of the fold
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			d_q     <= d_sat;
			run_q   <= run_rd;
			stats_q <= stats_cur;
		end
		if (state_q == S_FOLD) begin
			acc_q <= acc;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_vld_q || rsp.ready;

	// sequencer next state, memory writes and response
	always_comb begin
		state_d    = state_q;
		produce    = 1'b0;
		res_status = status_q;
		res_stats  = '0;
		stamp_we   = 1'b0;
		stamp_wa   = m_in;
		stamp_wd   = req.now_us;
		run_we     = 1'b0;
		run_wa     = m_in;
		run_wd     = '0;
		stats_we   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_LOAD;
				end
				// new top starts timing from zero
				if (stk_ctl.push) begin
					stamp_we = 1'b1;
					run_we   = 1'b1;
				end
			end
			S_LOAD: begin
				case (op_q)
					OP_PUSH, OP_POP: begin
						state_d = S_FOLD;
					end
					OP_READ: begin
						res_stats = stats_cur;
						if (out_free) begin
							produce = 1'b1;
							state_d = S_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							produce = 1'b1;
							state_d = S_IDLE;
						end
					end
				endcase
			end
			S_FOLD: begin
				if (op_q == OP_PUSH) begin
					// pause the previous top
					run_we = has_prev_q;
					run_wa = top_q;
					run_wd = acc;
					if (out_free) begin
						produce = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				// close the run and resume the metric below
				stats_we  = 1'b1;
				stamp_we  = has_below_q;
				stamp_wa  = below_q;
				stamp_wd  = now_q;
				res_stats = stats_upd;
				if (out_free) begin
					produce = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (produce) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_status_q <= res_status;
			out_stats_q  <= res_stats;
			out_depth_q  <= DEPTH_OUT_W'(depth_q);
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.sum_us      = out_stats_q.total;
	assign rsp.max_us      = out_stats_q.longest;
	assign rsp.run_count   = out_stats_q.runs;
	assign rsp.stack_depth = out_depth_q;

endmodule

>>> sv/npf_chk.sv
// ----------------------------------------------------------------------------
// npf_chk: port-level checks of the section profiler
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module npf_chk import npf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [STATUS_W-1:0]    rsp_status,
	input logic [SUM_W-1:0]       rsp_sum_us,
	input logic [RUN_W-1:0]       rsp_max_us,
	input logic [CNT_W-1:0]       rsp_run_count,
	input logic [DEPTH_OUT_W-1:0] rsp_stack_depth
);

	// one request in flight: no acceptance right after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in progress");

	// errors report no statistics
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status != ST_OK)) |->
		(rsp_sum_us == '0) && (rsp_max_us == '0) && (rsp_run_count == '0))
		else $error("error response carries statistics");

	// longest run never exceeds the interval cap
	a_max_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_max_us <= CAP_US))
		else $error("max run above the cap");

	// a pop on an empty stack reports depth zero
	a_empty_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_stack_depth == '0))
		else $error("empty status with nonzero depth");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_status) && $stable(rsp_sum_us)))
		else $error("stalled response changed");

endmodule

bind nested_section_latency_profiler_top npf_chk u_npf_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_sum_us      (rsp.sum_us),
	.rsp_max_us      (rsp.max_us),
	.rsp_run_count   (rsp.run_count),
	.rsp_stack_depth (rsp.stack_depth)
);

>>> verif/npf_profile_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npf_profile_checker: response checker of the section profiler
// Watches the request and response channels, keeps its own copy of the
// open-section stack and the per-metric timing and statistics, and compares
// every response field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module npf_profile_checker import npf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	npf_req_if   req,
	npf_rsp_if   rsp,
	output int   fails,
	output int   pending,
	output int   checked,
	output int   rejects,
	output int   capped
);

	localparam int NSTK = STACK_DEPTH_DEF;
	localparam int NMET = METRIC_COUNT_DEF;

	typedef struct packed {
		status_t                status;
		logic [SUM_W-1:0]       sum;
		logic [RUN_W-1:0]       longest;
		logic [CNT_W-1:0]       runs;
		logic [DEPTH_OUT_W-1:0] depth;
	} reply_t;

	// shadow of the profiler state
	logic [METRIC_W-1:0] open_ids [NSTK];
	int unsigned         open_cnt;
	logic [TIME_W-1:0]   piece_start [NMET];
	logic [RUN_W-1:0]    run_acc [NMET];
	logic [SUM_W-1:0]    sum_tbl [NMET];
	logic [RUN_W-1:0]    max_tbl [NMET];
	logic [CNT_W-1:0]    cnt_tbl [NMET];

	reply_t replies_due [$];

	// add the piece since the last start to the current run, both capped at 600 s
	function automatic void fold_piece(input int m, input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] gap;
		logic [RUN_W:0]    acc;
		gap = t - piece_start[m];
		if (gap > TIME_W'(CAP_US))
			gap = TIME_W'(CAP_US);
		acc = {1'b0, run_acc[m]} + (RUN_W+1)'(gap);
		if (acc > (RUN_W+1)'(CAP_US))
			acc = (RUN_W+1)'(CAP_US);
		run_acc[m] = acc[RUN_W-1:0];
	endfunction

	// apply one request to the shadow state and form its reply
	function automatic reply_t profile_step(input req_type_t kind,
			input logic [METRIC_W-1:0] m, input logic [TIME_W-1:0] t);
		reply_t         r;
		logic           dup;
		int             top;
		logic [SUM_W:0] s;
		r = '0;
		r.status = ST_OK;
		dup = 1'b0;
		case (kind)
			REQ_PUSH: begin
				for (int i = 0; i < NSTK; i++)
					if (i < open_cnt && open_ids[i] == m)
						dup = 1'b1;
				if (int'(m) >= NMET)
					r.status = ST_RANGE;
				else if (open_cnt >= NSTK)
					r.status = ST_FULL;
				else if (dup)
					r.status = ST_DUP;
				else begin
					// pause the enclosing metric
					if (open_cnt > 0)
						fold_piece(int'(open_ids[open_cnt-1]), t);
					open_ids[open_cnt] = m;
					open_cnt++;
					piece_start[m] = t;
					run_acc[m] = '0;
				end
			end
			REQ_POP: begin
				if (open_cnt == 0)
					r.status = ST_EMPTY;
				else begin
					top = int'(open_ids[open_cnt-1]);
					fold_piece(top, t);
					s = {1'b0, sum_tbl[top]} + (SUM_W+1)'(run_acc[top]);
					sum_tbl[top] = s[SUM_W] ? '1 : s[SUM_W-1:0];
					if (run_acc[top] > max_tbl[top])
						max_tbl[top] = run_acc[top];
					if (cnt_tbl[top] != '1)
						cnt_tbl[top] = cnt_tbl[top] + CNT_W'(1);
					run_acc[top] = '0;
					// enclosing metric resumes timing
					if (open_cnt > 1)
						piece_start[open_ids[open_cnt-2]] = t;
					open_cnt--;
					r.sum = sum_tbl[top];
					r.longest = max_tbl[top];
					r.runs = cnt_tbl[top];
				end
			end
			REQ_READ: begin
				if (int'(m) >= NMET)
					r.status = ST_RANGE;
				else begin
					r.sum = sum_tbl[m];
					r.longest = max_tbl[m];
					r.runs = cnt_tbl[m];
				end
			end
			default: ;
		endcase
		r.depth = DEPTH_OUT_W'(open_cnt);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
			input logic [SUM_W-1:0] want);
		fails++;
		if (fails <= 40)
			$display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
	endtask

	// predict on each request, check on each response
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			open_cnt = 0;
			for (int i = 0; i < NMET; i++) begin
				piece_start[i] = '0;
				run_acc[i] = '0;
				sum_tbl[i] = '0;
				max_tbl[i] = '0;
				cnt_tbl[i] = '0;
			end
			replies_due.delete();
			fails = 0;
			checked = 0;
			rejects = 0;
			capped = 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status = status_t'(rsp.status);
				got.sum = rsp.sum_us;
				got.longest = rsp.max_us;
				got.runs = rsp.run_count;
				got.depth = rsp.stack_depth;
				if (replies_due.size() == 0)
					report_mismatch("unrequested response status", SUM_W'(got.status), '0);
				else begin
					want = replies_due.pop_front();
					checked++;
					if (want.status != ST_OK)
						rejects++;
					if (want.status == ST_OK && want.longest == CAP_US)
						capped++;
					if (got.status != want.status)
						report_mismatch("status", SUM_W'(got.status), SUM_W'(want.status));
					if (got.sum != want.sum)
						report_mismatch("sum_us", got.sum, want.sum);
					if (got.longest != want.longest)
						report_mismatch("max_us", SUM_W'(got.longest), SUM_W'(want.longest));
					if (got.runs != want.runs)
						report_mismatch("run_count", SUM_W'(got.runs), SUM_W'(want.runs));
					if (got.depth != want.depth)
						report_mismatch("stack_depth", SUM_W'(got.depth), SUM_W'(want.depth));
				end
			end
			if (req.valid && req.ready)
				replies_due.push_back(profile_step(req_type_t'(req.req_type), req.metric,
					req.now_us));
			pending <= replies_due.size();
		end
	end

endmodule

>>> verif/tb_nested_section_latency_profiler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_section_latency_profiler_top: testbench of the section profiler
// Drives a directed set of nesting, error and timing corner cases, then
// random push/pop/read/no-op traffic in phases of sender gaps and receiver stalls,
// with long receiver hold-offs and sender pauses; a checker module beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_nested_section_latency_profiler_top;
	import npf_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          LONG_HOLD   = 300;
	localparam int          PHASE_ITEMS = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	npf_req_if req_ch ();
	npf_rsp_if rsp_ch ();

	int fails;
	int pending;
	int checked;
	int rejects;
	int capped;

	int          gap_pct = 0;
	int          stall_pct = 0;
	int          hold_asked = 0;
	int          hold_served;
	int          sent = 0;
	int unsigned cycles = 0;

	logic [TIME_W-1:0]   stamp_us = '0;
	logic [METRIC_W-1:0] open_list [$];

	nested_section_latency_profiler_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	npf_profile_checker profile_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.fails   (fails),
		.pending (pending),
		.checked (checked),
		.rejects (rejects),
		.capped  (capped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// response ready: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		hold_served = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served++;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic on_stack(input logic [METRIC_W-1:0] m);
		foreach (open_list[i])
			if (open_list[i] == m)
				return 1'b1;
		return 1'b0;
	endfunction

	// mostly small steps, some long or capped intervals, backward steps and jumps
	function automatic logic [TIME_W-1:0] next_stamp();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 78)
			stamp_us = stamp_us + TIME_W'($urandom_range(0, 2000));
		else if (r < 86)
			stamp_us = stamp_us + TIME_W'($urandom_range(0, 700_000_000));
		else if (r < 90)
			stamp_us = stamp_us + TIME_W'(600_000_000) + TIME_W'($urandom_range(0, 1));
		else if (r < 95)
			stamp_us = stamp_us - TIME_W'($urandom_range(1, 5000));
		else
			stamp_us = {16'($urandom), 32'($urandom)};
		return stamp_us;
	endfunction

	// one request, held until accepted; keeps a rough copy of the stack for shaping
	task automatic send_req(input req_type_t kind, input logic [METRIC_W-1:0] m,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.metric <= m;
		req_ch.now_us <= t;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		if (kind == REQ_PUSH && open_list.size() < STACK_DEPTH_DEF && !on_stack(m))
			open_list.push_back(m);
		else if (kind == REQ_POP && open_list.size() > 0)
			void'(open_list.pop_back());
	endtask

	// stop offering and wait for every reply
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// random request biased toward well-formed nesting
	task automatic rand_item();
		int unsigned         r;
		int unsigned         push_pct;
		logic [METRIC_W-1:0] m;
		r = $urandom_range(0, 99);
		m = METRIC_W'($urandom);
		if (r < 10)
			send_req(REQ_READ, m, next_stamp());
		else if (r < 13)
			send_req(REQ_NOP, m, next_stamp());
		else if (r < 16 && open_list.size() > 0)
			send_req(REQ_PUSH, open_list[$urandom_range(0, open_list.size() - 1)],
				next_stamp());
		else begin
			push_pct = (open_list.size() < 3) ? 70 : (open_list.size() < 7) ? 50 : 35;
			if ($urandom_range(0, 99) < push_pct) begin
				for (int k = 0; k < 8 && on_stack(m); k++)
					m = METRIC_W'($urandom);
				send_req(REQ_PUSH, m, next_stamp());
			end else
				send_req(REQ_POP, m, next_stamp());
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_PUSH;
		req_ch.metric = '0;
		req_ch.now_us = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, idle reads, unused code
		send_req(REQ_POP, 5'd0, 48'd0);
		send_req(REQ_READ, 5'd31, 48'd0);
		send_req(REQ_NOP, 5'd31, '1);
		// duplicate push, then a run split into pieces that exceeds 600 s
		send_req(REQ_PUSH, 5'd31, 48'd1000);
		send_req(REQ_PUSH, 5'd31, 48'd1010);
		send_req(REQ_PUSH, 5'd0, 48'd400_001_000);
		send_req(REQ_POP, 5'd0, 48'd400_001_005);
		send_req(REQ_POP, 5'd0, 48'd700_001_005);
		// timestamp wrapping forward, then going backwards
		send_req(REQ_PUSH, 5'd5, 48'hFFFF_FFFF_FF00);
		send_req(REQ_POP, 5'd5, 48'h10);
		send_req(REQ_PUSH, 5'd6, 48'd5000);
		send_req(REQ_POP, 5'd6, 48'd4000);
		// fill the stack; full takes priority over duplicate
		for (int k = 1; k <= STACK_DEPTH_DEF; k++)
			send_req(REQ_PUSH, METRIC_W'(k), 48'd10_000 + 48'(k * 7));
		send_req(REQ_PUSH, 5'd9, 48'd20_000);
		send_req(REQ_PUSH, 5'd1, 48'd20_001);
		send_req(REQ_POP, 5'd0, 48'd30_000);
		send_req(REQ_POP, 5'd0, 48'd45_000);
		send_req(REQ_READ, 5'd31, 48'd45_001);
		wait_drained();
		stamp_us = 48'd50_000;

		// random traffic under different idling mixes
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 50; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 50; end
				default: begin gap_pct = 28; stall_pct = 28; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ((p == 0 || p == 3) && i == 60)
					hold_asked++;
				if (i == PHASE_ITEMS / 2)
					wait_drained();
				rand_item();
			end
			wait_drained();
		end
		stall_pct = 0;
		repeat (16) @(posedge clk);

		$display("sent %0d requests over four idling mixes with long receiver hold-offs",
			sent);
		$display("checked %0d replies: %0d error statuses, %0d runs capped at 600 s",
			checked, rejects, capped);
		if (fails == 0)
			$display("*** PASSED ***");
		else begin
			$display("%0d mismatches", fails);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/npf_pkg.sv
sv/npf_req_if.sv
sv/npf_rsp_if.sv
sv/npf_ram.sv
sv/npf_cell.sv
sv/nested_section_latency_profiler_top.sv
sv/npf_chk.sv
verif/npf_profile_checker.sv
verif/tb_nested_section_latency_profiler_top.sv
